// File: rtl/lphm_pkg.sv
`timescale 1ns / 1ps

package lphm_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int KEY_W          = 40;
  localparam int VAL_W          = 32;
  localparam int LIVE_W         = 11;
  localparam int LIVE_MAX       = 2047;

  localparam logic OP_ENTER = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic probe;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic probe_done;
  } dp_status_t;

endpackage

// File: rtl/lphm_ctrl.sv
`timescale 1ns / 1ps

module lphm_ctrl
  import lphm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_PROBE;
      end
      S_PROBE: begin
        if (status_i.probe_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == S_CLEAR);
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.probe  = (state_q == S_PROBE);
    cmd_o.commit = (state_q == S_FINISH) && out_free;
    in_ready_o   = (state_q == S_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/lphm_datapath.sv
`timescale 1ns / 1ps

module lphm_datapath
  import lphm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic              opcode_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic [VAL_W-1:0]  result_value_o,
  output logic              result_status_o,
  output logic [LIVE_W-1:0] live_entries_o,
  output logic              half_full_o
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int SAT_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

  slot_t mem [TABLE_SIZE];
  slot_t rdata_q;

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  logic [ADDR_W-1:0] clr_addr_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [ADDR_W-1:0] chk_addr_q;
  logic [CNT_W-1:0]  issued_q;
  logic [CNT_W-1:0]  checked_q;
  logic              rd_vld_q;
  logic              found_q;
  logic [ADDR_W-1:0] match_addr_q;
  logic [VAL_W-1:0]  match_val_q;
  logic              free_vld_q;
  logic [ADDR_W-1:0] free_addr_q;
  logic [CNT_W-1:0]  live_q;

  logic [ADDR_W-1:0] home;
  logic              key_eq;
  logic              stop_hit;
  logic              free_cand;
  logic              probe_last;
  logic              issue;

  logic              is_enter;
  logic              tgt_ok;
  logic [ADDR_W-1:0] tgt;
  logic              was_live;
  logic              do_write;
  logic [CNT_W-1:0]  live_new;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  slot_t             wdata;

  assign home = key_i[ADDR_W-1:0] + key_i[ADDR_W+9:10] + key_i[ADDR_W+19:20];

  assign key_eq     = rdata_q.used && (rdata_q.key == key_q);
  assign stop_hit   = !rdata_q.used || key_eq;
  assign free_cand  = !rdata_q.used || (rdata_q.value == '0);
  assign probe_last = cmd_i.probe && rd_vld_q &&
                      (stop_hit || (checked_q == CNT_W'(TABLE_SIZE - 1)));
  assign issue      = cmd_i.probe && !probe_last && (issued_q != CNT_W'(TABLE_SIZE));

  assign status_o.clear_done = cmd_i.clear && (clr_addr_q == '1);
  assign status_o.probe_done = probe_last;

  assign is_enter = (op_q == OP_ENTER);
  assign tgt_ok   = found_q || free_vld_q;
  assign tgt      = found_q ? match_addr_q : free_addr_q;
  assign was_live = found_q && (match_val_q != '0);
  assign do_write = cmd_i.commit && is_enter && tgt_ok;

  always_comb begin
    live_new = live_q;
    if (do_write) begin
      if (!was_live && (val_q != '0)) begin
        live_new = live_q + CNT_W'(1);
      end else if (was_live && (val_q == '0)) begin
        live_new = live_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    we         = cmd_i.clear || do_write;
    waddr      = cmd_i.clear ? clr_addr_q : tgt;
    wdata      = '0;
    if (!cmd_i.clear) begin
      wdata.used  = 1'b1;
      wdata.key   = key_q;
      wdata.value = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[raddr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (issue) begin
      chk_addr_q <= raddr_q;
    end
    if (cmd_i.commit) begin
      result_value_o  <= (!is_enter && found_q) ? match_val_q : '0;
      result_status_o <= is_enter && !tgt_ok;
      live_entries_o  <= (SAT_W'(live_new) > SAT_W'(LIVE_MAX)) ?
                         LIVE_W'(LIVE_MAX) : LIVE_W'(live_new);
      half_full_o     <= (live_new >= CNT_W'(TABLE_SIZE / 2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      raddr_q      <= '0;
      issued_q     <= '0;
      checked_q    <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      match_addr_q <= '0;
      match_val_q  <= '0;
      free_vld_q   <= 1'b0;
      free_addr_q  <= '0;
      live_q       <= '0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.load) begin
        raddr_q    <= home;
        issued_q   <= '0;
        checked_q  <= '0;
        found_q    <= 1'b0;
        free_vld_q <= 1'b0;
      end
      if (issue) begin
        raddr_q  <= raddr_q + ADDR_W'(1);
        issued_q <= issued_q + CNT_W'(1);
      end
      if (cmd_i.probe && rd_vld_q) begin
        checked_q <= checked_q + CNT_W'(1);
        if (key_eq) begin
          found_q      <= 1'b1;
          match_addr_q <= chk_addr_q;
          match_val_q  <= rdata_q.value;
        end
        if (free_cand && !free_vld_q) begin
          free_vld_q  <= 1'b1;
          free_addr_q <= chk_addr_q;
        end
      end
      if (cmd_i.commit) begin
        live_q <= live_new;
      end
    end
  end

endmodule

// File: rtl/linear_probe_hash_map.sv
`timescale 1ns / 1ps

// Key-to-value map over a single-port table of TABLE_SIZE slots (a power of two) with
// linear probing. After reset the block runs a clearing pass, one slot per cycle, with
// in_ready_o low. Each item passes through an accept step, a read issue, slot checks
// streamed through the table's registered read port at one slot a cycle, and a commit
// step that writes the slot for an enter with a target and loads the result register;
// the commit waits while an earlier result is not taken. A full wrap examines all
// TABLE_SIZE slots. A waiting result does not block the next item from being accepted.

module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  result_value_o,
  output logic              status_o,
  output logic [LIVE_W-1:0] live_entries_o,
  output logic              half_full_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  lphm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  lphm_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .value_i         (value_i),
    .result_value_o  (result_value_o),
    .result_status_o (status_o),
    .live_entries_o  (live_entries_o),
    .half_full_o     (half_full_o)
  );

endmodule

// File: rtl/lphm_checker.sv
`timescale 1ns / 1ps

module lphm_checker #(
  parameter int TABLE_SIZE = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        opcode_i,
  input logic [39:0] key_i,
  input logic [31:0] value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_value_o,
  input logic        status_o,
  input logic [10:0] live_entries_o,
  input logic        half_full_o
);

  // A result that is not taken keeps its whole payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
      $stable(status_o) && $stable(live_entries_o) && $stable(half_full_o))
    else $error("stalled result changed");

  // A rejected enter never reports a stored value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_value_o == 32'd0)
    else $error("rejected item carries a value");

  // The half-capacity flag follows the reported count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(live_entries_o) >= 32'(TABLE_SIZE / 2)) |-> half_full_o)
    else $error("half_full flag missing");

  // One item is in work at a time, so in_ready_o drops once an item is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in work");

endmodule

bind linear_probe_hash_map lphm_checker #(.TABLE_SIZE(TABLE_SIZE)) u_lphm_checker (.*);

// File: verif/linear_probe_hash_map_test.sv
`timescale 1ns / 1ps

module linear_probe_hash_map_test;
  import lphm_pkg::*;

  localparam int TS = TABLE_SIZE_DEF;
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;
  localparam int POOL_N = 48;
  localparam longint CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              status;
    logic [LIVE_W-1:0] live;
    logic              half;
  } map_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              opcode;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic              out_valid;
  logic              out_ready;
  logic [VAL_W-1:0]  result_value;
  logic              status;
  logic [LIVE_W-1:0] live_entries;
  logic              half_full;

  bit                map_used [TS];
  logic [KEY_W-1:0]  map_key [TS];
  logic [VAL_W-1:0]  map_val [TS];
  int unsigned       map_live;
  map_result_t       access_results_q[$];
  logic [KEY_W-1:0]  key_pool [POOL_N];
  int                fail_count;
  longint            cycle_count;
  bit                no_idle;

  linear_probe_hash_map #(
    .TABLE_SIZE(TS)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .key_i         (key),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_value_o(result_value),
    .status_o      (status),
    .live_entries_o(live_entries),
    .half_full_o   (half_full)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned home_slot(logic [KEY_W-1:0] k);
    logic [63:0] k64;
    logic [63:0] h;
    k64 = 64'(k);
    h = k64 + (k64 >> 10) + (k64 >> 20);
    return int'(h % TS);
  endfunction

  function automatic map_result_t map_access(logic op, logic [KEY_W-1:0] k,
                                             logic [VAL_W-1:0] v);
    map_result_t r;
    int unsigned idx;
    int unsigned at;
    bit hit;
    bit free_found;
    r = '0;
    r.status = STATUS_DONE;
    hit = 0;
    free_found = 0;
    at = 0;
    idx = home_slot(k);
    for (int n = 0; n < TS; n++) begin
      if (!map_used[idx]) break;
      if (map_key[idx] == k) begin
        hit = 1;
        at = idx;
        break;
      end
      idx = (idx + 1) % TS;
    end
    if (op == OP_LOOKUP) begin
      if (hit) r.value = map_val[at];
    end else begin
      if (!hit) begin
        idx = home_slot(k);
        for (int n = 0; n < TS; n++) begin
          if (!map_used[idx] || map_val[idx] == '0) begin
            free_found = 1;
            at = idx;
            break;
          end
          idx = (idx + 1) % TS;
        end
      end
      if (!hit && !free_found) begin
        r.status = STATUS_REJECTED;
      end else begin
        if (!(map_used[at] && map_val[at] != '0)) map_live++;
        if (v == '0) map_live--;
        map_used[at] = 1;
        map_key[at] = k;
        map_val[at] = v;
      end
    end
    r.live = (map_live > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(map_live);
    r.half = (map_live >= TS / 2);
    return r;
  endfunction

  // Builds a key whose home slot is the given one, so that chains and clusters form.
  function automatic logic [KEY_W-1:0] key_for_home(int unsigned home);
    logic [29:0] hi;
    logic [9:0]  lo;
    hi = 30'($urandom);
    lo = 10'(home - hi - (hi >> 10));
    return {hi, lo};
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return '0;
    if (pick == 2) return '1;
    return $urandom;
  endfunction

  task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    access_results_q.push_back(map_access(op, k, v));
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    map_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (access_results_q.size() == 0) begin
        $error("unexpected result: result_value %0h", result_value);
        fail_count++;
      end else begin
        exp_r = access_results_q.pop_front();
        if (result_value !== exp_r.value) begin
          $error("result_value: expected %0h, actual %0h", exp_r.value, result_value);
          fail_count++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0h, actual %0h", exp_r.status, status);
          fail_count++;
        end
        if (live_entries !== exp_r.live) begin
          $error("live_entries: expected %0d, actual %0d", exp_r.live, live_entries);
          fail_count++;
        end
        if (half_full !== exp_r.half) begin
          $error("half_full: expected %0h, actual %0h", exp_r.half, half_full);
          fail_count++;
        end
      end
    end
  end

  task automatic test_basic_access();
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_ENTER, '0, '1);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_ENTER, '1, 32'd1);
    send_item(OP_LOOKUP, '1, '1);
    send_item(OP_ENTER, '0, 32'h5A5A_A5A5);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_ENTER, 40'hAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_item(OP_ENTER, 40'h55_5555_5555, 32'h5555_5555);
    send_item(OP_LOOKUP, 40'hAA_AAAA_AAAA, '0);
    // Deleting leaves a tombstone; a later enter of that key reuses it.
    send_item(OP_ENTER, '0, '0);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_ENTER, '0, 32'h1234_5678);
    send_item(OP_ENTER, 40'd12345, '0);
    send_item(OP_LOOKUP, 40'd12345, '0);
    send_item(OP_ENTER, 40'd12345, 32'd7);
    // Two keys on one home slot: the second is found through the first's tombstone.
    ka = key_for_home(500);
    kb = key_for_home(500);
    send_item(OP_ENTER, ka, 32'hDEAD_BEEF);
    send_item(OP_ENTER, kb, 32'hCAFE_F00D);
    send_item(OP_ENTER, ka, '0);
    send_item(OP_LOOKUP, kb, '0);
    send_item(OP_LOOKUP, ka, '0);
  endtask

  task automatic test_random_access(input int count);
    int unsigned base;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < POOL_N; i++) begin
      base = $urandom_range(0, TS - 1);
      if (i % 2 == 0) key_pool[i] = key_for_home((base % 4) + 700);
      else key_pool[i] = {8'($urandom), 32'($urandom)};
    end
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      k = key_pool[$urandom_range(0, POOL_N - 1)];
      if ($urandom_range(0, 99) < 55) begin
        send_item(OP_ENTER, k, random_value());
      end else begin
        if ($urandom_range(0, 4) == 0) k = {8'($urandom), 32'($urandom)};
        send_item(OP_LOOKUP, k, $urandom);
      end
    end
    no_idle = 0;
  endtask

  task automatic test_full_table();
    int unsigned n;
    n = 0;
    while (map_live < TS) begin
      no_idle = (n >= TS / 2);
      send_item(OP_ENTER, 40'hC3_0000_0000 | KEY_W'(n), $urandom | 32'd1);
      n++;
    end
    no_idle = 0;
    send_item(OP_ENTER, 40'h3C_1111_2222, 32'd99);
    send_item(OP_LOOKUP, 40'h3C_1111_2222, '0);
    send_item(OP_ENTER, 40'h3C_1111_2222, '0);
    send_item(OP_LOOKUP, 40'hC3_0000_0000, '0);
    send_item(OP_ENTER, 40'hC3_0000_0001, 32'h0BAD_F00D);
    send_item(OP_LOOKUP, 40'hC3_0000_0001, '0);
  endtask

  task automatic test_after_full(input int count);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < 40; i++) begin
      send_item(OP_ENTER, 40'hC3_0000_0000 | KEY_W'($urandom_range(0, TS - 1)), '0);
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) k = {8'($urandom), 32'($urandom)};
      else k = 40'hC3_0000_0000 | KEY_W'($urandom_range(0, TS - 1));
      send_item($urandom_range(0, 1) ? OP_ENTER : OP_LOOKUP, k, random_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = OP_LOOKUP;
    key = '0;
    value = '0;
    no_idle = 0;
    fail_count = 0;
    cycle_count = 0;
    map_live = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_access();
    test_random_access(460);
    test_full_table();
    test_after_full(60);

    @(negedge clk);
    in_valid <= 1'b0;
    while (access_results_q.size() != 0) @(posedge clk);
    repeat (TS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
